/* design/ppt_pkg.sv */
// Shared constants, types and the arctangent table of the path tracker.
// No dependencies; the interface, sequencer and top-level files refer to it by scoped names.
`timescale 1ns / 1ps

package ppt_pkg;

    localparam int PATH_CAPACITY   = 256;
    localparam int ADDR_W          = $clog2(PATH_CAPACITY);
    localparam int CNT_W           = ADDR_W + 1;
    localparam int LOOKAHEAD_STEPS = 3;

    localparam int REG_W   = 31;
    localparam int COORD_W = 32;
    localparam int HEAD_W  = 20;
    localparam int ANG_W   = 24;
    localparam int VEC_W   = 36;
    localparam int DIV_W   = 50;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam logic signed [ANG_W-1:0] Q_PI      = 24'sd205887;
    localparam logic signed [ANG_W-1:0] Q_HALF_PI = 24'sd102944;
    localparam logic signed [ANG_W-1:0] Q_TWO_PI  = 24'sd411775;
    localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 36'sd39797;
    localparam logic [63:0] MIN_LOOK_D2 = 64'd429496;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CFG_MAX_SPEED = 2'd0,
        CFG_MAX_TURN  = 2'd1,
        CFG_GOAL_TOL  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [REG_W-1:0] max_speed;
        logic [REG_W-1:0] max_turn;
        logic [REG_W-1:0] goal_tol;
    } ppt_cfg_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [COORD_W-1:0] wdata_x;
        logic [COORD_W-1:0] wdata_y;
        logic [ADDR_W-1:0]  raddr;
    } ppt_mem_req_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            4'd0:    r = 24'sd51472;
            4'd1:    r = 24'sd30386;
            4'd2:    r = 24'sd16055;
            4'd3:    r = 24'sd8150;
            4'd4:    r = 24'sd4091;
            4'd5:    r = 24'sd2047;
            4'd6:    r = 24'sd1024;
            4'd7:    r = 24'sd512;
            4'd8:    r = 24'sd256;
            4'd9:    r = 24'sd128;
            4'd10:   r = 24'sd64;
            4'd11:   r = 24'sd32;
            4'd12:   r = 24'sd16;
            4'd13:   r = 24'sd8;
            4'd14:   r = 24'sd4;
            default: r = 24'sd2;
        endcase
        return r;
    endfunction

endpackage

/* design/ppt_if.sv */
// Valid/ready channel interfaces for command words and result words.
// Depends on ppt_pkg for field widths.
`timescale 1ns / 1ps

interface ppt_in_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         action;
    logic signed [ppt_pkg::COORD_W-1:0] pos_x;
    logic signed [ppt_pkg::COORD_W-1:0] pos_y;
    logic signed [ppt_pkg::HEAD_W-1:0]  heading;

    modport source (output valid, action, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, action, pos_x, pos_y, heading, output ready);
endinterface

interface ppt_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ppt_pkg::COORD_W-1:0] linear_speed;
    logic signed [ppt_pkg::COORD_W-1:0] turn_rate;
    logic                               goal_reached;
    logic [7:0]                         nearest_index;

    modport source (output valid, linear_speed, turn_rate, goal_reached, nearest_index,
                    input ready);
    modport sink   (input valid, linear_speed, turn_rate, goal_reached, nearest_index,
                    output ready);
endinterface

/* design/ppt_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module ppt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/ppt_seq.sv */
// Query sequencer: path scan, CORDIC, square root and divide on one shared datapath.
// Depends on ppt_pkg and ppt_if; the path memories sit outside.
`timescale 1ns / 1ps

module ppt_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ppt_pkg::ppt_cfg_t          cfg,
    ppt_in_if.sink                     req,
    ppt_out_if.source                  rsp,
    output ppt_pkg::ppt_mem_req_t      mem,
    input  logic [ppt_pkg::COORD_W-1:0] rd_x,
    input  logic [ppt_pkg::COORD_W-1:0] rd_y
);

    localparam int AW = ppt_pkg::ADDR_W;
    localparam int CW = ppt_pkg::CNT_W;
    localparam int VW = ppt_pkg::VEC_W;
    localparam int GW = ppt_pkg::ANG_W;
    localparam int DW = ppt_pkg::DIV_W;
    localparam int STEPW = ppt_pkg::STEP_W;

    typedef enum logic [4:0] {
        S_IDLE, S_TOL, S_RD, S_DAT, S_MX, S_MY, S_SUM, S_APRE, S_ATAN, S_ERR, S_WRAP,
        S_SPRE, S_SC, S_VMUL, S_VCLAMP, S_SMUL, S_SQRT, S_DIV, S_WCLAMP, S_OUT
    } state_t;

    state_t state_reg;
    logic   tgt_phase_reg;

    logic [CW-1:0]        cnt_reg;
    logic signed [31:0]   px_reg, py_reg;
    logic signed [19:0]   hd_reg;
    logic [AW-1:0]        idx_reg, near_reg;
    logic signed [32:0]   dx_reg, dy_reg;
    logic [63:0]          sq_reg, sq2_reg, best_reg, tol2_reg, d2t_reg;
    logic signed [VW-1:0] cx_reg, cy_reg;
    logic signed [GW-1:0] cz_reg;
    logic [STEPW-1:0]     k_reg;
    logic                 flip_reg;
    logic [63:0]          prod_reg;
    logic                 neg_reg;
    logic [63:0]          sv_reg, sres_reg, sbit_reg;
    logic [31:0]          rem_reg;
    logic [DW-1:0]        num_reg;
    logic [5:0]           dcnt_reg;
    logic signed [31:0]   lin_reg, turn_reg;
    logic                 goal_reg;
    logic [AW-1:0]        rnear_reg;
    logic                 ov_reg;
    logic signed [31:0]   olin_reg, oturn_reg;
    logic                 ogoal_reg;
    logic [7:0]           onear_reg;

    logic                 in_acc;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    logic signed [32:0]   dx_c, dy_c;
    logic [64:0]          sum65;
    logic [63:0]          dist_sat;
    logic                 take;
    logic [AW-1:0]        near_new;
    logic [CW:0]          tsum;
    logic [AW-1:0]        last_idx, tgt_idx;
    logic signed [VW-1:0] xs, ys, c_val, s_val;
    logic signed [GW-1:0] at;
    logic signed [65:0]   vp, vx, vmax_s, vhalf_s;
    logic [63:0]          strial;
    logic [32:0]          dtrial;
    logic [DW-1:0]        wclamp;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] a;
        a = v[32] ? -v : v;
        return a[31:0];
    endfunction

    function automatic logic [31:0] magv(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] a;
        a = v[VW-1] ? -v : v;
        return a[31:0];
    endfunction

    assign in_acc    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign mem.we      = in_acc && (req.action == ppt_pkg::ACT_APPEND)
                         && (cnt_reg < CW'(ppt_pkg::PATH_CAPACITY));
    assign mem.waddr   = cnt_reg[AW-1:0];
    assign mem.wdata_x = req.pos_x;
    assign mem.wdata_y = req.pos_y;
    assign mem.raddr   = idx_reg;

    assign rsp.valid         = ov_reg;
    assign rsp.linear_speed  = olin_reg;
    assign rsp.turn_rate     = oturn_reg;
    assign rsp.goal_reached  = ogoal_reg;
    assign rsp.nearest_index = onear_reg;

    assign dx_c = $signed({rd_x[31], rd_x}) - $signed({px_reg[31], px_reg});
    assign dy_c = $signed({rd_y[31], rd_y}) - $signed({py_reg[31], py_reg});

    assign sum65    = {1'b0, sq_reg} + {1'b0, sq2_reg};
    assign dist_sat = sum65[64] ? '1 : sum65[63:0];

    assign take     = (idx_reg == AW'(1)) || (dist_sat < best_reg);
    assign near_new = take ? idx_reg : near_reg;
    assign last_idx = AW'(cnt_reg - CW'(1));
    assign tsum     = {1'b0, {(CW-AW){1'b0}}, near_new} + (CW+1)'(ppt_pkg::LOOKAHEAD_STEPS);
    assign tgt_idx  = (tsum > (CW+1)'(last_idx)) ? last_idx : AW'(tsum);

    assign xs = cx_reg >>> k_reg;
    assign ys = cy_reg >>> k_reg;
    assign at = ppt_pkg::atan_entry(k_reg);

    assign c_val = flip_reg ? -cx_reg : cx_reg;
    assign s_val = flip_reg ? -cy_reg : cy_reg;

    assign vp      = neg_reg ? -$signed({2'b00, prod_reg}) : $signed({2'b00, prod_reg});
    assign vx      = vp >>> 16;
    assign vmax_s  = $signed({35'd0, cfg.max_speed});
    assign vhalf_s = $signed({36'd0, cfg.max_speed[ppt_pkg::REG_W-1:1]});

    assign strial = sres_reg + sbit_reg;
    assign dtrial = {rem_reg, num_reg[DW-1]};
    assign wclamp = (num_reg > DW'(cfg.max_turn)) ? DW'(cfg.max_turn) : num_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_TOL:
            begin
                mul_a = {1'b0, cfg.goal_tol};
                mul_b = {1'b0, cfg.goal_tol};
            end
            S_MX:
            begin
                mul_a = mag33(dx_reg);
                mul_b = mag33(dx_reg);
            end
            S_MY:
            begin
                mul_a = mag33(dy_reg);
                mul_b = mag33(dy_reg);
            end
            S_VMUL:
            begin
                mul_a = {1'b0, cfg.max_speed};
                mul_b = magv(c_val);
            end
            S_SMUL:
            begin
                mul_a = {1'b0, cfg.max_speed};
                mul_b = magv(s_val);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tgt_phase_reg <= 1'b0;
            cnt_reg       <= '0;
            ov_reg        <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (rsp.ready && (state_reg != S_OUT))
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        px_reg <= req.pos_x;
                        py_reg <= req.pos_y;
                        hd_reg <= req.heading;
                        if (req.action == ppt_pkg::ACT_CLEAR)
                        begin
                            cnt_reg <= '0;
                        end
                        else if (req.action == ppt_pkg::ACT_APPEND)
                        begin
                            if (cnt_reg < CW'(ppt_pkg::PATH_CAPACITY))
                            begin
                                cnt_reg <= cnt_reg + CW'(1);
                            end
                        end
                        else if (req.action == ppt_pkg::ACT_QUERY)
                        begin
                            lin_reg   <= '0;
                            turn_reg  <= '0;
                            goal_reg  <= 1'b0;
                            rnear_reg <= '0;
                            if (cnt_reg < CW'(2))
                            begin
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                idx_reg       <= AW'(1);
                                tgt_phase_reg <= 1'b0;
                                state_reg     <= S_TOL;
                            end
                        end
                    end
                end
                S_TOL:
                begin
                    tol2_reg  <= mul_p;
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_DAT;
                end
                S_DAT:
                begin
                    dx_reg    <= dx_c;
                    dy_reg    <= dy_c;
                    state_reg <= S_MX;
                end
                S_MX:
                begin
                    sq_reg    <= mul_p;
                    state_reg <= S_MY;
                end
                S_MY:
                begin
                    sq2_reg   <= mul_p;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (tgt_phase_reg)
                    begin
                        d2t_reg   <= dist_sat;
                        state_reg <= S_APRE;
                    end
                    else
                    begin
                        best_reg <= take ? dist_sat : best_reg;
                        near_reg <= near_new;
                        if (idx_reg == last_idx)
                        begin
                            rnear_reg <= near_new;
                            if (dist_sat < tol2_reg)
                            begin
                                goal_reg  <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                idx_reg       <= tgt_idx;
                                tgt_phase_reg <= 1'b1;
                                state_reg     <= S_RD;
                            end
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                S_APRE:
                begin
                    k_reg <= '0;
                    if (dx_reg == '0 && dy_reg == '0)
                    begin
                        cz_reg    <= '0;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        state_reg <= S_ATAN;
                        if (dx_reg < 0)
                        begin
                            if (dy_reg >= 0)
                            begin
                                cx_reg <= VW'(dy_reg);
                                cy_reg <= -VW'(dx_reg);
                                cz_reg <= ppt_pkg::Q_HALF_PI;
                            end
                            else
                            begin
                                cx_reg <= -VW'(dy_reg);
                                cy_reg <= VW'(dx_reg);
                                cz_reg <= -ppt_pkg::Q_HALF_PI;
                            end
                        end
                        else
                        begin
                            cx_reg <= VW'(dx_reg);
                            cy_reg <= VW'(dy_reg);
                            cz_reg <= '0;
                        end
                    end
                end
                S_ATAN:
                begin
                    if (cy_reg > 0)
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + at;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - at;
                    end
                    k_reg <= k_reg + STEPW'(1);
                    if (k_reg == STEPW'(ppt_pkg::CORDIC_STEPS - 1))
                    begin
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    cz_reg    <= cz_reg - GW'(hd_reg);
                    state_reg <= S_WRAP;
                end
                S_WRAP:
                begin
                    if (cz_reg > ppt_pkg::Q_PI)
                    begin
                        cz_reg <= cz_reg - ppt_pkg::Q_TWO_PI;
                    end
                    else if (cz_reg < -ppt_pkg::Q_PI)
                    begin
                        cz_reg <= cz_reg + ppt_pkg::Q_TWO_PI;
                    end
                    else
                    begin
                        state_reg <= S_SPRE;
                    end
                end
                S_SPRE:
                begin
                    cx_reg <= ppt_pkg::CORDIC_GAIN;
                    cy_reg <= '0;
                    k_reg  <= '0;
                    if (cz_reg > ppt_pkg::Q_HALF_PI)
                    begin
                        cz_reg   <= cz_reg - ppt_pkg::Q_PI;
                        flip_reg <= 1'b1;
                    end
                    else if (cz_reg < -ppt_pkg::Q_HALF_PI)
                    begin
                        cz_reg   <= cz_reg + ppt_pkg::Q_PI;
                        flip_reg <= 1'b1;
                    end
                    else
                    begin
                        flip_reg <= 1'b0;
                    end
                    state_reg <= S_SC;
                end
                S_SC:
                begin
                    if (cz_reg >= 0)
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - at;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + at;
                    end
                    k_reg <= k_reg + STEPW'(1);
                    if (k_reg == STEPW'(ppt_pkg::CORDIC_STEPS - 1))
                    begin
                        state_reg <= S_VMUL;
                    end
                end
                S_VMUL:
                begin
                    prod_reg  <= mul_p;
                    neg_reg   <= c_val[VW-1];
                    state_reg <= S_VCLAMP;
                end
                S_VCLAMP:
                begin
                    if (vx > vmax_s)
                    begin
                        lin_reg <= 32'(vmax_s);
                    end
                    else if (vx < -vhalf_s)
                    begin
                        lin_reg <= 32'(-vhalf_s);
                    end
                    else
                    begin
                        lin_reg <= 32'(vx);
                    end
                    state_reg <= S_SMUL;
                end
                S_SMUL:
                begin
                    prod_reg <= mul_p;
                    neg_reg  <= s_val[VW-1];
                    sv_reg   <= d2t_reg;
                    sres_reg <= '0;
                    sbit_reg <= 64'd1 << 62;
                    if (d2t_reg > ppt_pkg::MIN_LOOK_D2)
                    begin
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        turn_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_SQRT:
                begin
                    if (sv_reg >= strial)
                    begin
                        sv_reg   <= sv_reg - strial;
                        sres_reg <= (sres_reg >> 1) + sbit_reg;
                    end
                    else
                    begin
                        sres_reg <= sres_reg >> 1;
                    end
                    sbit_reg <= sbit_reg >> 2;
                    if (sbit_reg == 64'd1)
                    begin
                        rem_reg   <= '0;
                        num_reg   <= {prod_reg[DW-2:0], 1'b0};
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (dtrial >= {1'b0, sres_reg[31:0]})
                    begin
                        rem_reg <= 32'(dtrial - {1'b0, sres_reg[31:0]});
                        num_reg <= {num_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= dtrial[31:0];
                        num_reg <= {num_reg[DW-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'(DW - 1))
                    begin
                        state_reg <= S_WCLAMP;
                    end
                end
                S_WCLAMP:
                begin
                    turn_reg  <= neg_reg ? -32'(wclamp) : 32'(wclamp);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ov_reg || rsp.ready)
                    begin
                        ov_reg    <= 1'b1;
                        olin_reg  <= lin_reg;
                        oturn_reg <= turn_reg;
                        ogoal_reg <= goal_reg;
                        onear_reg <= 8'(rnear_reg);
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ppt_pkg::PATH_CAPACITY))
        else $error("point count beyond capacity");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> (CW'(idx_reg) < cnt_reg))
        else $error("scan index past stored points");

    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        mem.we |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("append did not advance count");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT || state_reg == S_DIV) |-> !req.ready)
        else $error("ready during arithmetic");
`endif

endmodule

/* design/pure_pursuit_path_tracker_unit.sv */
// Pure pursuit path tracker top level: configuration registers, path memories, sequencer.
// Depends on ppt_pkg, ppt_if, ppt_ram and ppt_seq.
//
// Clear and append words are handled in the idle state; an append beyond 256 points is dropped.
// A pose query scans for the nearest point; each point passes the read, data, x-square,
// y-square and sum states on the shared path read address and multiplier. Unless the
// goal is reached, 16-step CORDIC bearing and sine/cosine and (look-ahead point not too
// near) a 32-step square root and 50-step divider run one step a cycle. The result waits
// in an output register; the next word is taken once the result is in that register.
`timescale 1ns / 1ps

module pure_pursuit_path_tracker_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [ppt_pkg::REG_W-1:0]   cfg_wdata,
    ppt_in_if.sink                      req,
    ppt_out_if.source                   rsp
);

    ppt_pkg::ppt_cfg_t     cfg_reg;
    ppt_pkg::ppt_mem_req_t mem;
    logic [ppt_pkg::COORD_W-1:0] rd_x, rd_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_speed <= 31'd32768;
            cfg_reg.max_turn  <= 31'd65536;
            cfg_reg.goal_tol  <= 31'd6554;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppt_pkg::CFG_MAX_SPEED: cfg_reg.max_speed <= cfg_wdata;
                ppt_pkg::CFG_MAX_TURN:  cfg_reg.max_turn  <= cfg_wdata;
                ppt_pkg::CFG_GOAL_TOL:  cfg_reg.goal_tol  <= cfg_wdata;
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    ppt_ram #(.WIDTH(ppt_pkg::COORD_W), .DEPTH(ppt_pkg::PATH_CAPACITY)) u_ram_x (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata_x),
        .raddr (mem.raddr),
        .rdata (rd_x)
    );

    ppt_ram #(.WIDTH(ppt_pkg::COORD_W), .DEPTH(ppt_pkg::PATH_CAPACITY)) u_ram_y (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata_y),
        .raddr (mem.raddr),
        .rdata (rd_y)
    );

    ppt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .req   (req),
        .rsp   (rsp),
        .mem   (mem),
        .rd_x  (rd_x),
        .rd_y  (rd_y)
    );

endmodule
